>>> rtl/core/nomoto_heading_integrator_defines.svh
// Assertion macros shared by the heading integrator RTL.
`ifndef NOMOTO_HEADING_INTEGRATOR_DEFINES_SVH
`define NOMOTO_HEADING_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NHI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NHI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/nhi_pkg.sv
// Package of the heading integrator: widths, constants, control word and microprogram.
package nhi_pkg;

    // Field widths of the transactions.
    localparam int SPD_W  = 24;
    localparam int CMD_W  = 17;
    localparam int DT_W   = 20;
    localparam int NZ_W   = 20;
    localparam int HDG_W  = 25;
    localparam int YAW_W  = 19;
    localparam int ROT_W  = 26;

    // Configuration register widths.
    localparam int GPL_W  = 24;
    localparam int ITL_W  = 24;
    localparam int BIAS_W = 16;
    localparam int NG_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GPL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NGAIN = 3'd5;

    localparam logic [GPL_W-1:0] GPL_RST = 24'd54395;
    localparam logic [ITL_W-1:0] ITL_RST = 24'd43116;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 33;
    localparam int MB_W = 32;
    localparam int PR_W = MA_W + MB_W;

    // Rudder clip, angle and conversion constants.
    localparam int RUD_W = 16;
    localparam logic signed [RUD_W-1:0] RUD_LIM = 16'sd25600;
    localparam logic [HDG_W-1:0] DEG360 = 25'd23592960;
    localparam logic [HDG_W-1:0] DEG180 = 25'd11796480;
    localparam logic signed [MB_W-1:0] RAD_K = 32'sd74961321;
    // floor(2^40 / 360 degrees in Q16), for the modulo quotient estimate.
    localparam logic signed [MB_W-1:0] RECIP_Q40 = 32'sd46603;
    localparam logic signed [ROT_W-1:0] ROT_MAX = 26'sh1FF_FFFF;
    localparam logic signed [ROT_W-1:0] ROT_MIN = 26'sh200_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Microprogram step counter.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_MUL_DG  = 5'd6;
    localparam logic [PC_W-1:0] PC_WB_ROT  = 5'd7;

    // Multiplier operand A selects.
    localparam int SEL_W = 4;
    localparam logic [SEL_W-1:0] A_NONE  = 4'd0;
    localparam logic [SEL_W-1:0] A_GPL   = 4'd1;
    localparam logic [SEL_W-1:0] A_SPD   = 4'd2;
    localparam logic [SEL_W-1:0] A_KM    = 4'd3;
    localparam logic [SEL_W-1:0] A_G1    = 4'd4;
    localparam logic [SEL_W-1:0] A_NOISE = 4'd5;
    localparam logic [SEL_W-1:0] A_DIFF  = 4'd6;
    localparam logic [SEL_W-1:0] A_ROT   = 4'd7;
    localparam logic [SEL_W-1:0] A_H     = 4'd8;
    localparam logic [SEL_W-1:0] A_Q     = 4'd9;
    localparam logic [SEL_W-1:0] A_YAW   = 4'd10;

    // Multiplier operand B selects.
    localparam logic [SEL_W-1:0] B_NONE   = 4'd0;
    localparam logic [SEL_W-1:0] B_SPD    = 4'd1;
    localparam logic [SEL_W-1:0] B_ITL    = 4'd2;
    localparam logic [SEL_W-1:0] B_RUD    = 4'd3;
    localparam logic [SEL_W-1:0] B_DT     = 4'd4;
    localparam logic [SEL_W-1:0] B_NGAIN  = 4'd5;
    localparam logic [SEL_W-1:0] B_G      = 4'd6;
    localparam logic [SEL_W-1:0] B_RECIP  = 4'd7;
    localparam logic [SEL_W-1:0] B_DEG360 = 4'd8;
    localparam logic [SEL_W-1:0] B_RADK   = 4'd9;

    // Write-back destinations of the registered product.
    localparam logic [SEL_W-1:0] WB_NONE = 4'd0;
    localparam logic [SEL_W-1:0] WB_KM   = 4'd1;
    localparam logic [SEL_W-1:0] WB_G1   = 4'd2;
    localparam logic [SEL_W-1:0] WB_DIFF = 4'd3;
    localparam logic [SEL_W-1:0] WB_G    = 4'd4;
    localparam logic [SEL_W-1:0] WB_NZ   = 4'd5;
    localparam logic [SEL_W-1:0] WB_ROT  = 4'd6;
    localparam logic [SEL_W-1:0] WB_H    = 4'd7;
    localparam logic [SEL_W-1:0] WB_Q    = 4'd8;
    localparam logic [SEL_W-1:0] WB_R    = 4'd9;
    localparam logic [SEL_W-1:0] WB_HS   = 4'd10;
    localparam logic [SEL_W-1:0] WB_OUT  = 4'd11;

    // Jump conditions.
    localparam logic [1:0] C_NONE     = 2'd0;
    localparam logic [1:0] C_ALWAYS   = 2'd1;
    localparam logic [1:0] C_NO_NOISE = 2'd2;

    typedef struct packed {
        logic             mul_en;
        logic [SEL_W-1:0] a_sel;
        logic [SEL_W-1:0] b_sel;
        logic [SEL_W-1:0] wb;
        logic [1:0]       cond;
        logic [PC_W-1:0]  target;
        logic             done;
    } t_ctrl;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic noise_on;
    } t_stat;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic busy;
        logic at_done;
    } t_seq;

    localparam t_ctrl CTRL_NOP = '0;

    // Control store. Each word multiplies into the product register and/or
    // writes back the product left by the previous word.
    function automatic t_ctrl nhi_ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = CTRL_NOP;
        unique case (pc)
            5'd0: begin
                c.mul_en = 1'b1; c.a_sel = A_GPL; c.b_sel = B_SPD;
            end
            5'd1: begin
                c.wb = WB_KM;
                c.mul_en = 1'b1; c.a_sel = A_SPD; c.b_sel = B_ITL;
            end
            5'd2: begin
                c.wb = WB_G1;
                c.mul_en = 1'b1; c.a_sel = A_KM; c.b_sel = B_RUD;
            end
            5'd3: begin
                c.wb = WB_DIFF;
                c.mul_en = 1'b1; c.a_sel = A_G1; c.b_sel = B_DT;
            end
            5'd4: begin
                c.wb = WB_G;
                c.mul_en = 1'b1; c.a_sel = A_NOISE; c.b_sel = B_NGAIN;
                c.cond = C_NO_NOISE; c.target = PC_MUL_DG;
            end
            5'd5: begin
                c.wb = WB_NZ;
                c.mul_en = 1'b1; c.a_sel = A_DIFF; c.b_sel = B_G;
                c.cond = C_ALWAYS; c.target = PC_WB_ROT;
            end
            5'd6: begin
                c.mul_en = 1'b1; c.a_sel = A_DIFF; c.b_sel = B_G;
            end
            5'd7: begin
                c.wb = WB_ROT;
            end
            5'd8: begin
                c.mul_en = 1'b1; c.a_sel = A_ROT; c.b_sel = B_DT;
            end
            5'd9: begin
                c.wb = WB_H;
            end
            5'd10: begin
                c.mul_en = 1'b1; c.a_sel = A_H; c.b_sel = B_RECIP;
            end
            5'd11: begin
                c.wb = WB_Q;
            end
            5'd12: begin
                c.mul_en = 1'b1; c.a_sel = A_Q; c.b_sel = B_DEG360;
            end
            5'd13: begin
                c.wb = WB_R;
            end
            5'd14: begin
                c.wb = WB_HS;
            end
            5'd15: begin
                c.mul_en = 1'b1; c.a_sel = A_YAW; c.b_sel = B_RADK;
            end
            5'd16: begin
                c.wb = WB_OUT; c.done = 1'b1;
            end
            default: begin
                c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/nhi_ifs.sv
// Channel interfaces of the heading integrator: input, result and configuration.
interface nhi_in_if import nhi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] speed;
    logic signed [CMD_W-1:0] rudder_cmd;
    logic        [DT_W-1:0]  step_time;
    logic signed [NZ_W-1:0]  noise_sample;

    modport source (output valid, output speed, output rudder_cmd, output step_time,
                    output noise_sample, input ready);
    modport sink (input valid, input speed, input rudder_cmd, input step_time,
                  input noise_sample, output ready);
endinterface

interface nhi_out_if import nhi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [HDG_W-1:0] heading;
    logic signed [YAW_W-1:0] yaw;
    logic signed [ROT_W-1:0] rot_dps;

    modport source (output valid, output heading, output yaw, output rot_dps,
                    input ready);
    modport sink (input valid, input heading, input yaw, input rot_dps,
                  output ready);
endinterface

interface nhi_cfg_if import nhi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/nhi_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module nhi_seq import nhi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_blocked,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output t_seq  o_seq
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_busy;
    logic            n_busy;
    t_ctrl           rom_word;
    logic            stall;
    logic            step;
    logic            taken;

    // Fetch and decide whether this step may retire.
    always_comb begin
        rom_word = nhi_ucode(r_pc);
        stall    = rom_word.done && i_out_blocked;
        step     = r_busy && !stall;
        o_ctrl   = step ? rom_word : CTRL_NOP;
        o_seq.busy    = r_busy;
        o_seq.at_done = r_busy && rom_word.done;
    end

    // Jump condition decode.
    always_comb begin
        unique case (rom_word.cond)
            C_NONE:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_NOISE: taken = !i_stat.noise_on;
            default:    taken = 1'b0;
        endcase
    end

    // Next step address and busy flag.
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = '0;
            n_busy = 1'b1;
        end else if (step) begin
            if (rom_word.done) begin
                n_busy = 1'b0;
            end else if (taken) begin
                n_pc = rom_word.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

endmodule

>>> rtl/core/nhi_dpath.sv
// Datapath: configuration registers, operand capture, shared multiplier and write-back logic.
module nhi_dpath import nhi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [SPD_W-1:0] i_speed,
    input  logic signed [CMD_W-1:0] i_rudder_cmd,
    input  logic        [DT_W-1:0]  i_step_time,
    input  logic signed [NZ_W-1:0]  i_noise_sample,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data,
    input  t_ctrl                   i_ctrl,
    output t_stat                   o_stat,
    output logic        [HDG_W-1:0] o_heading,
    output logic signed [YAW_W-1:0] o_yaw,
    output logic signed [ROT_W-1:0] o_rot_dps
);

    localparam int RS_W  = CMD_W + 1;   // command plus bias
    localparam int RD_W  = CMD_W + 2;   // after negation
    localparam int TGT_W = 40;          // target rate before the difference
    localparam int DW_W  = TGT_W + 1;
    localparam int GW_W  = 38;          // gain before saturation
    localparam int NZP_W = 29;          // scaled noise
    localparam int DG_W  = 48;          // relaxation step
    localparam int RSUM_W = 50;
    localparam int H_W   = 32;          // heading before the modulo
    localparam int Q_W   = 8;           // quotient of the modulo
    localparam int YS_W  = HDG_W + 1;   // signed heading

    localparam logic signed [PR_W-1:0] HALF8  = PR_W'(128);
    localparam logic signed [PR_W-1:0] HALF16 = PR_W'(32768);
    localparam logic signed [PR_W-1:0] HALF32 =
        $signed({{(PR_W-32){1'b0}}, 32'h8000_0000});
    localparam logic signed [H_W-1:0]  DEG360_H  = H_W'($signed({1'b0, DEG360}));
    localparam logic signed [YS_W-1:0] DEG360_Y  = $signed({1'b0, DEG360});
    localparam logic signed [MB_W-1:0] DEG360_B  = MB_W'($signed({1'b0, DEG360}));

    // Configuration registers.
    logic        [GPL_W-1:0]  r_gpl;
    logic        [ITL_W-1:0]  r_itl;
    logic signed [BIAS_W-1:0] r_bias;
    logic                     r_rev;
    logic                     r_nen;
    logic        [NG_W-1:0]   r_ngain;

    // Item operands and intermediate values.
    logic signed [SPD_W-1:0]  r_spd;
    logic        [DT_W-1:0]   r_dt;
    logic signed [NZ_W-1:0]   r_noise;
    logic signed [RUD_W-1:0]  r_rud;
    logic signed [MA_W-1:0]   r_km;
    logic signed [MA_W-1:0]   r_g1;
    logic signed [31:0]       r_diff;
    logic signed [MB_W-1:0]   r_g;
    logic signed [NZP_W-1:0]  r_nz;
    logic signed [H_W-1:0]    r_h;
    logic signed [Q_W-1:0]    r_q;
    logic signed [PR_W-1:0]   r_prod;

    // Carried state.
    logic signed [ROT_W-1:0]  r_rot;
    logic        [HDG_W-1:0]  r_hs;

    // Result register.
    logic        [HDG_W-1:0]  r_o_hdg;
    logic signed [YAW_W-1:0]  r_o_yaw;
    logic signed [ROT_W-1:0]  r_o_rot;

    logic signed [RS_W-1:0]   rud_sum;
    logic signed [RD_W-1:0]   rud_dir;
    logic signed [RUD_W-1:0]  rud_clip;
    logic signed [MA_W-1:0]   a_op;
    logic signed [MB_W-1:0]   b_op;
    logic signed [PR_W-1:0]   n_prod;
    logic signed [PR_W-1:0]   p_r8;
    logic signed [PR_W-1:0]   p_r16;
    logic signed [PR_W-1:0]   p_r32;
    logic signed [DW_W-1:0]   diff_w;
    logic signed [31:0]       n_diff;
    logic signed [GW_W-1:0]   g_w;
    logic signed [MB_W-1:0]   n_g;
    logic signed [RSUM_W-1:0] rot_w;
    logic signed [ROT_W-1:0]  n_rot;
    logic signed [H_W-1:0]    n_h;
    logic signed [H_W:0]      rem_w;
    logic signed [H_W-1:0]    hs_w;
    logic        [HDG_W-1:0]  n_hs;
    logic signed [YS_W-1:0]   hp;
    logic signed [YS_W-1:0]   yaw_src;
    logic signed [YAW_W-1:0]  n_yaw;

    // Rudder: command plus bias, zero at rest, reversed, clipped.
    always_comb begin
        rud_sum = RS_W'(i_rudder_cmd) + RS_W'(r_bias);
        if (i_speed == '0) begin
            rud_sum = '0;
        end
        rud_dir = r_rev ? -RD_W'(rud_sum) : RD_W'(rud_sum);
        if (rud_dir > RD_W'(RUD_LIM)) begin
            rud_clip = RUD_LIM;
        end else if (rud_dir < -RD_W'(RUD_LIM)) begin
            rud_clip = -RUD_LIM;
        end else begin
            rud_clip = RUD_W'(rud_dir);
        end
    end

    // Signed heading in (-180, 180], negated for the yaw product.
    always_comb begin
        if (r_hs > DEG180) begin
            hp = $signed({1'b0, r_hs}) - DEG360_Y;
        end else begin
            hp = $signed({1'b0, r_hs});
        end
        yaw_src = -hp;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (i_ctrl.a_sel)
            A_GPL:   a_op = MA_W'($signed({1'b0, r_gpl}));
            A_SPD:   a_op = MA_W'(r_spd);
            A_KM:    a_op = r_km;
            A_G1:    a_op = r_g1;
            A_NOISE: a_op = MA_W'(r_noise);
            A_DIFF:  a_op = MA_W'(r_diff);
            A_ROT:   a_op = MA_W'(r_rot);
            A_H:     a_op = MA_W'(r_h);
            A_Q:     a_op = MA_W'(r_q);
            A_YAW:   a_op = MA_W'(yaw_src);
            default: a_op = '0;
        endcase
        unique case (i_ctrl.b_sel)
            B_SPD:    b_op = MB_W'(r_spd);
            B_ITL:    b_op = MB_W'($signed({1'b0, r_itl}));
            B_RUD:    b_op = MB_W'(r_rud);
            B_DT:     b_op = MB_W'($signed({1'b0, r_dt}));
            B_NGAIN:  b_op = MB_W'($signed({1'b0, r_ngain}));
            B_G:      b_op = r_g;
            B_RECIP:  b_op = RECIP_Q40;
            B_DEG360: b_op = DEG360_B;
            B_RADK:   b_op = RAD_K;
            default:  b_op = '0;
        endcase
        n_prod = PR_W'(a_op) * PR_W'(b_op);
    end

    // Round-to-nearest shifts of the registered product.
    always_comb begin
        p_r8  = (r_prod + HALF8) >>> 8;
        p_r16 = (r_prod + HALF16) >>> 16;
        p_r32 = (r_prod + HALF32) >>> 32;
    end

    // Write-back values.
    always_comb begin
        // Difference between target and current rate, saturated to 32 bits.
        diff_w = DW_W'($signed(p_r8[TGT_W-1:0])) - DW_W'(r_rot);
        if (diff_w > DW_W'(S32_MAX)) begin
            n_diff = S32_MAX;
        end else if (diff_w < DW_W'(S32_MIN)) begin
            n_diff = S32_MIN;
        end else begin
            n_diff = diff_w[31:0];
        end

        // Relaxation gain, saturated to 32 bits.
        g_w = $signed(p_r16[GW_W-1:0]);
        if (g_w > GW_W'(S32_MAX)) begin
            n_g = S32_MAX;
        end else if (g_w < GW_W'(S32_MIN)) begin
            n_g = S32_MIN;
        end else begin
            n_g = g_w[MB_W-1:0];
        end

        // New turn rate, saturated.
        rot_w = RSUM_W'($signed(p_r16[DG_W-1:0])) + RSUM_W'(r_rot) + RSUM_W'(r_nz);
        if (rot_w > RSUM_W'(ROT_MAX)) begin
            n_rot = ROT_MAX;
        end else if (rot_w < RSUM_W'(ROT_MIN)) begin
            n_rot = ROT_MIN;
        end else begin
            n_rot = rot_w[ROT_W-1:0];
        end

        // Integrated heading before the wrap.
        n_h = $signed(p_r16[H_W-1:0]) + H_W'($signed({1'b0, r_hs}));

        // Remainder against the estimated quotient, then one correction.
        rem_w = (H_W+1)'(r_h) - $signed(r_prod[H_W:0]);
        if (r_h < 0) begin
            hs_w = r_h + DEG360_H;
        end else if (r_h >= DEG360_H) begin
            hs_w = r_h - DEG360_H;
        end else begin
            hs_w = r_h;
        end
        n_hs = hs_w[HDG_W-1:0];

        n_yaw = $signed(p_r32[YAW_W-1:0]);
    end

    assign o_stat.noise_on = r_nen && (r_spd != '0);

    // Configuration registers and carried state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpl   <= GPL_RST;
            r_itl   <= ITL_RST;
            r_bias  <= '0;
            r_rev   <= 1'b0;
            r_nen   <= 1'b0;
            r_ngain <= '0;
            r_rot   <= '0;
            r_hs    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GPL:   r_gpl   <= i_cfg_data[GPL_W-1:0];
                    REG_ITL:   r_itl   <= i_cfg_data[ITL_W-1:0];
                    REG_BIAS:  r_bias  <= $signed(i_cfg_data[BIAS_W-1:0]);
                    REG_REV:   r_rev   <= i_cfg_data[0];
                    REG_NEN:   r_nen   <= i_cfg_data[0];
                    REG_NGAIN: r_ngain <= i_cfg_data[NG_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctrl.wb == WB_ROT) begin
                r_rot <= n_rot;
            end
            if (i_ctrl.wb == WB_HS) begin
                r_hs <= n_hs;
            end
        end
    end

    // Operand capture, product register and intermediate write-back.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_spd   <= i_speed;
            r_dt    <= i_step_time;
            r_noise <= i_noise_sample;
            r_rud   <= rud_clip;
            r_nz    <= '0;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
        unique case (i_ctrl.wb)
            WB_NONE: ;
            WB_KM:   r_km   <= $signed(p_r16[MA_W-1:0]);
            WB_G1:   r_g1   <= $signed(p_r16[MA_W-1:0]);
            WB_DIFF: r_diff <= n_diff;
            WB_G:    r_g    <= n_g;
            WB_NZ:   r_nz   <= $signed(p_r8[NZP_W-1:0]);
            WB_ROT:  ;
            WB_H:    r_h    <= n_h;
            WB_Q:    r_q    <= $signed(r_prod[40+Q_W-1:40]);
            WB_R:    r_h    <= rem_w[H_W-1:0];
            WB_HS:   ;
            WB_OUT: begin
                r_o_hdg <= r_hs;
                r_o_yaw <= n_yaw;
                r_o_rot <= r_rot;
            end
            default: ;
        endcase
    end

    assign o_heading = r_o_hdg;
    assign o_yaw     = r_o_yaw;
    assign o_rot_dps = r_o_rot;

endmodule

>>> rtl/core/nomoto_heading_integrator.sv
// Top level of the heading integrator: channels, sequencer, datapath and result register.
//
// One tick of a first-order steering model per input transaction: the turn rate relaxes
// toward the rate the rudder demands, optional noise is added, and the heading is
// integrated and wrapped. One result transaction follows every input transaction.
// An item occupies the block for the same time from acceptance to the next possible
// acceptance, with or without noise: the 17-word control program drives a single shared
// 33 x 32 bit multiplier, at most one product per step, and runs 16 of its words for
// every item because the word that writes back the noise product and the word that
// does not sit on alternative branches; the next transaction is accepted once the last
// word has retired. A finished result waits in the output register while the next
// transaction is accepted; the program holds at its last step only if the previous
// result has not been taken yet. The configuration port always accepts writes;
// registers are to be written only while no item is in flight.
`include "nomoto_heading_integrator_defines.svh"

module nomoto_heading_integrator import nhi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nhi_in_if.sink    i_in,
    nhi_out_if.source o_out,
    nhi_cfg_if.sink   i_cfg
);

    t_ctrl ctrl;
    t_stat stat;
    t_seq  seq_st;
    logic  in_fire;
    logic  cfg_we;
    logic  out_blocked;
    logic  r_out_valid;

    // Handshakes.
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign out_blocked = r_out_valid && !o_out.ready;
    assign i_in.ready  = !seq_st.busy;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;

    nhi_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_fire),
        .i_out_blocked (out_blocked),
        .i_stat        (stat),
        .o_ctrl        (ctrl),
        .o_seq         (seq_st)
    );

    nhi_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_fire),
        .i_speed        (i_in.speed),
        .i_rudder_cmd   (i_in.rudder_cmd),
        .i_step_time    (i_in.step_time),
        .i_noise_sample (i_in.noise_sample),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .o_heading      (o_out.heading),
        .o_yaw          (o_out.yaw),
        .o_rot_dps      (o_out.rot_dps)
    );

    // Result valid: set when the last step retires, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An accepted transaction starts the program.
    `NHI_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, in_fire, seq_st.busy,
                    "item accepted but sequencer idle")
    // The last step must not retire while the previous result is still waiting.
    `NHI_ASSERT_NXT(a_hold_done, i_clk, i_rst_n, seq_st.at_done && out_blocked, seq_st.busy,
                    "result step retired over a pending result")
    // Heading is wrapped into one turn.
    `NHI_ASSERT_IMP(a_hdg_range, i_clk, i_rst_n, o_out.valid, o_out.heading < DEG360,
                    "heading not wrapped")
    // Yaw is minus the heading: nonpositive for headings up to half a turn.
    `NHI_ASSERT_IMP(a_yaw_sign, i_clk, i_rst_n, o_out.valid && (o_out.heading <= DEG180),
                    o_out.yaw <= 19'sd0, "yaw sign does not match heading")

endmodule

>>> tb/sv/nhi_heading_checker.sv
// Checker of the heading integrator: watches the channels, predicts each tick and compares.
`timescale 1ns / 100ps

module nhi_heading_checker import nhi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nhi_in_if    in_ch,
    nhi_out_if   out_ch,
    nhi_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // One predicted result transaction.
    typedef struct packed {
        logic        [HDG_W-1:0] heading;
        logic signed [YAW_W-1:0] yaw;
        logic signed [ROT_W-1:0] rot_dps;
    } t_fix;

    localparam longint FULL_TURN = longint'(DEG360);
    localparam longint HALF_TURN = longint'(DEG180);
    localparam longint RUD_CLIP  = longint'(RUD_LIM);
    localparam longint RAD_SCALE = longint'(RAD_K);
    localparam longint RATE_HI   = longint'(ROT_MAX);
    localparam longint RATE_LO   = longint'(ROT_MIN);
    localparam longint WORD_HI   = longint'(S32_MAX);
    localparam longint WORD_LO   = longint'(S32_MIN);

    // Fixes predicted for accepted ticks, oldest first.
    t_fix due_fixes[$];

    // Mirror of the configuration registers.
    logic        [GPL_W-1:0]  gain_len;
    logic        [ITL_W-1:0]  inv_time_len;
    logic signed [BIAS_W-1:0] bias;
    logic                     reverse;
    logic                     noise_on;
    logic        [NG_W-1:0]   noise_gain;

    // Mirror of the vessel state.
    logic signed [ROT_W-1:0] rate_state;
    logic        [HDG_W-1:0] heading_state;

    int fails;
    int checked;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    // Round to nearest with ties toward plus infinity, then drop n fraction bits.
    function automatic longint round_shift(input longint x, input int n);
        longint t;
        t = x + (longint'(1) <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= 100) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    // One tick of the steering model: relax the turn rate, add noise, integrate heading.
    task automatic advance_vessel(input logic signed [SPD_W-1:0] speed,
                                  input logic signed [CMD_W-1:0] cmd,
                                  input logic        [DT_W-1:0]  step,
                                  input logic signed [NZ_W-1:0]  noise,
                                  output t_fix fix);
        longint spd, dt, rud, km, tgt, diff, g, rot, h, y;
        spd = longint'(speed);
        dt  = longint'(step);

        rud = longint'(cmd) + longint'(bias);
        if (spd == 0) rud = 0;
        if (reverse) rud = -rud;
        rud = clip(rud, -RUD_CLIP, RUD_CLIP);

        km   = round_shift(longint'(gain_len) * spd, 16);
        tgt  = round_shift(km * rud, 8);
        diff = clip(tgt - longint'(rate_state), WORD_LO, WORD_HI);

        g = round_shift(spd * longint'(inv_time_len), 16);
        g = clip(round_shift(g * dt, 16), WORD_LO, WORD_HI);

        rot = longint'(rate_state) + round_shift(diff * g, 16);
        if (noise_on && spd != 0) rot += round_shift(longint'(noise) * longint'(noise_gain), 8);
        rot = clip(rot, RATE_LO, RATE_HI);

        h = longint'(heading_state) + round_shift(rot * dt, 16);
        h = h % FULL_TURN;
        if (h < 0) h += FULL_TURN;

        rate_state    = rot[ROT_W-1:0];
        heading_state = h[HDG_W-1:0];

        // Yaw is minus the heading folded into the half turn on either side.
        if (h > HALF_TURN) h -= FULL_TURN;
        y = round_shift(-h * RAD_SCALE, 32);

        fix.heading = heading_state;
        fix.yaw     = y[YAW_W-1:0];
        fix.rot_dps = rate_state;
    endtask

    // Register writes, result checks and predictions, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_fix fix;
        t_fix want;
        if (!i_rst_n) begin
            gain_len      = GPL_RST;
            inv_time_len  = ITL_RST;
            bias          = '0;
            reverse       = 1'b0;
            noise_on      = 1'b0;
            noise_gain    = '0;
            rate_state    = '0;
            heading_state = '0;
            due_fixes.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_GPL:   gain_len     = cfg_ch.data[GPL_W-1:0];
                    REG_ITL:   inv_time_len = cfg_ch.data[ITL_W-1:0];
                    REG_BIAS:  bias         = cfg_ch.data[BIAS_W-1:0];
                    REG_REV:   reverse      = cfg_ch.data[0];
                    REG_NEN:   noise_on     = cfg_ch.data[0];
                    REG_NGAIN: noise_gain   = cfg_ch.data[NG_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (out_ch.valid && out_ch.ready) begin
                checked++;
                if (due_fixes.size() == 0) begin
                    report_mismatch("result transaction with no tick waiting");
                end else begin
                    want = due_fixes.pop_front();
                    if (out_ch.heading !== want.heading)
                        report_mismatch($sformatf("heading got %0d expected %0d",
                                                  out_ch.heading, want.heading));
                    if (out_ch.yaw !== want.yaw)
                        report_mismatch($sformatf("yaw got %0d expected %0d",
                                                  out_ch.yaw, want.yaw));
                    if (out_ch.rot_dps !== want.rot_dps)
                        report_mismatch($sformatf("rot_dps got %0d expected %0d",
                                                  out_ch.rot_dps, want.rot_dps));
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                advance_vessel(in_ch.speed, in_ch.rudder_cmd, in_ch.step_time,
                               in_ch.noise_sample, fix);
                due_fixes.push_back(fix);
            end
        end
        o_pending <= due_fixes.size();
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top of the heading integrator: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb import nhi_pkg::*; ();

    localparam int RESET_CYCLES    = 5;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 1000000;

    // Index values past the register list; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [SPD_W-1:0] SPD_TOP = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic signed [SPD_W-1:0] SPD_BOT = {1'b1, {(SPD_W-1){1'b0}}};
    localparam logic signed [CMD_W-1:0] CMD_TOP = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic signed [CMD_W-1:0] CMD_BOT = {1'b1, {(CMD_W-1){1'b0}}};
    localparam logic        [DT_W-1:0]  DT_TOP  = '1;
    localparam logic signed [NZ_W-1:0]  NZ_TOP  = {1'b0, {(NZ_W-1){1'b1}}};
    localparam logic signed [NZ_W-1:0]  NZ_BOT  = {1'b1, {(NZ_W-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    int  fail_count;
    int  pending;
    int  results_checked;
    int  ticks_sent;
    int  reg_writes;
    int  settings_used;
    int  cycle_count;
    bit  calm;

    nhi_in_if  in_ch ();
    nhi_out_if out_ch ();
    nhi_cfg_if cfg_ch ();

    nomoto_heading_integrator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    nhi_heading_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (results_checked)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hold until every predicted fix has been taken from the block.
    task automatic wait_drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Offer one tick and wait for its transaction; then idle or keep valid up.
    task automatic send_tick(input logic signed [SPD_W-1:0] spd,
                             input logic signed [CMD_W-1:0] cmd,
                             input logic        [DT_W-1:0]  dt,
                             input logic signed [NZ_W-1:0]  nz,
                             input bit last);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.speed        <= spd;
        in_ch.rudder_cmd   <= cmd;
        in_ch.step_time    <= dt;
        in_ch.noise_sample <= nz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        ticks_sent++;
        gap = last ? 0 : idle_len();
        if (last || gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Register write, only once the block has gone idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        wait_drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
    endtask

    // Half the time fill the bits above the register width with junk.
    function automatic logic [CFG_DAT_W-1:0] pad_value(input logic [CFG_DAT_W-1:0] v,
                                                       input int width);
        logic [CFG_DAT_W-1:0] mask;
        logic [CFG_DAT_W-1:0] junk;
        mask = (CFG_DAT_W'(1) << width) - 1'b1;
        junk = CFG_DAT_W'($urandom());
        if ($urandom_range(0, 1) == 0) return v & mask;
        return (v & mask) | (junk & ~mask);
    endfunction

    // Program a full register setting, plus one write to an unused index.
    task automatic apply_setting(input logic [GPL_W-1:0] gpl, input logic [ITL_W-1:0] itl,
                                 input logic signed [BIAS_W-1:0] rbias, input logic rev,
                                 input logic nen, input logic [NG_W-1:0] ngain);
        write_reg(REG_GPL, gpl);
        write_reg(REG_ITL, itl);
        write_reg(REG_BIAS, pad_value({{(CFG_DAT_W-BIAS_W){rbias[BIAS_W-1]}}, rbias}, BIAS_W));
        write_reg(REG_REV, pad_value(CFG_DAT_W'(rev), 1));
        write_reg(REG_NEN, pad_value(CFG_DAT_W'(nen), 1));
        write_reg(REG_NGAIN, pad_value(CFG_DAT_W'(ngain), NG_W));
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DAT_W'($urandom()));
        settings_used++;
    endtask

    function automatic logic [GPL_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return GPL_W'($urandom());
            default: return GPL_W'($urandom_range(0, 262143));
        endcase
    endfunction

    // Random tick: mostly plausible sailing values, some extremes and raw bit patterns.
    task automatic random_tick(input bit last);
        logic signed [SPD_W-1:0] spd;
        logic signed [CMD_W-1:0] cmd;
        logic        [DT_W-1:0]  dt;
        logic signed [NZ_W-1:0]  nz;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) spd = '0;
        else if (r < 60) spd = SPD_W'($urandom_range(0, 983040) - 327680);
        else if (r < 70) begin
            case ($urandom_range(0, 3))
                0: spd = SPD_TOP;
                1: spd = SPD_BOT;
                2: spd = 1;
                default: spd = -1;
            endcase
        end else spd = SPD_W'($urandom());

        r = $urandom_range(0, 99);
        if (r < 50) cmd = CMD_W'($urandom_range(0, 60000) - 30000);
        else if (r < 60) cmd = $urandom_range(0, 1) ? CMD_TOP : CMD_BOT;
        else cmd = CMD_W'($urandom());

        r = $urandom_range(0, 99);
        if (r < 8) dt = '0;
        else if (r < 70) dt = DT_W'($urandom_range(1638, 16384));
        else if (r < 80) dt = $urandom_range(0, 1) ? DT_TOP : DT_W'(1);
        else dt = DT_W'($urandom());

        r = $urandom_range(0, 99);
        if (r < 10) nz = $urandom_range(0, 1) ? NZ_TOP : NZ_BOT;
        else if (r < 50) nz = NZ_W'($urandom_range(0, 13107) - 6553);
        else nz = NZ_W'($urandom());

        send_tick(spd, cmd, dt, nz, last);
    endtask

    // Result side back-pressure.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int  p;
        int  k;
        bit  hold;
        in_ch.valid        <= 1'b0;
        in_ch.speed        <= '0;
        in_ch.rudder_cmd   <= '0;
        in_ch.step_time    <= '0;
        in_ch.noise_sample <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        calm          = 1'b0;
        ticks_sent    = 0;
        reg_writes    = 0;
        settings_used = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks with the reset setting: zero speed, zero step, reverse
        // speed, commands past the clip and the field extremes.
        send_tick(0, 25600, 6554, 0, 0);
        send_tick(327680, 12800, 6554, 0, 0);
        send_tick(327680, 12800, 0, 0, 0);
        send_tick(-327680, -12800, 6554, 0, 0);
        send_tick(327680, CMD_TOP, 65536, 0, 0);
        send_tick(327680, CMD_BOT, 65536, 0, 0);
        send_tick(SPD_TOP, CMD_TOP, DT_TOP, NZ_TOP, 0);
        send_tick(SPD_BOT, CMD_BOT, DT_TOP, NZ_BOT, 1);

        // Largest gains, reversed rudder and full noise: intermediate saturation,
        // noise held off at zero speed, noise alone at zero step.
        apply_setting('1, '1, 25600, 1'b1, 1'b1, '1);
        send_tick(SPD_TOP, CMD_TOP, DT_TOP, NZ_TOP, 0);
        send_tick(SPD_BOT, CMD_BOT, DT_TOP, NZ_BOT, 0);
        send_tick(0, 12800, 6554, NZ_TOP, 0);
        send_tick(1, 0, 0, NZ_BOT, 0);
        send_tick(-1, 100, 1, 12345, 0);
        send_tick(327680, 0, 6554, -1, 1);

        // No gain at all, bias at minus the rudder clip.
        apply_setting('0, '0, -25600, 1'b0, 1'b1, 16'd256);
        send_tick(655360, 25600, 13107, 65536, 0);
        send_tick(655360, -25600, 13107, -65536, 0);
        send_tick(0, 0, 0, 0, 0);
        send_tick(SPD_TOP, CMD_BOT, 1, 1, 1);

        // Random phases, each under its own register setting.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting(GPL_RST, ITL_RST, '0, 1'b0, 1'b1, 16'd128);
                1: apply_setting('1, '1, 25600, 1'b1, 1'b1, '1);
                2: apply_setting('0, '0, -25600, 1'b0, 1'b0, '0);
                default: apply_setting(pick_gain(), pick_gain(),
                                       BIAS_W'($urandom_range(0, 51200) - 25600),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 3) == 0 ? 16'hFFFF
                                                                 : NG_W'($urandom_range(0, 1024)));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                hold = (k == ITEMS_PER_PHASE - 1) || ($urandom_range(0, 149) == 0);
                random_tick(hold);
                if (hold) wait_drain();
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks under %0d register settings with %0d register writes",
                 ticks_sent, settings_used, reg_writes);
        $display("compared %0d result transactions, %0d mismatches, %0d outstanding",
                 results_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
